@@ design/wlmp_pkg.sv @@
// ----------------------------------------------------------------------------
// wlmp_pkg
// Shared types and constants for the windowed local-maximum peak detector:
// beat payloads, configuration register indexes and field widths.
// ----------------------------------------------------------------------------
package wlmp_pkg;

  localparam int DATA_W      = 32;
  localparam int MAG_W       = 64;
  localparam int RADIUS_W    = 4;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 64;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_THRESHOLD_SQ = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] CFG_RADIUS       = CFG_INDEX_W'(1);

  // Register reset values
  localparam logic [MAG_W-1:0]    THRESHOLD_RESET = '0;
  localparam logic [RADIUS_W-1:0] RADIUS_RESET    = RADIUS_W'(1);

  // Input beat: one complex spectrum sample
  typedef struct packed {
    logic        [DATA_W-1:0] sample_frequency;
    logic signed [DATA_W-1:0] sample_real;
    logic signed [DATA_W-1:0] sample_imag;
    logic                     scan_last;
  } sample_t;

  // Output beat: one detected peak
  typedef struct packed {
    logic        [DATA_W-1:0] peak_frequency;
    logic signed [DATA_W-1:0] peak_real;
    logic signed [DATA_W-1:0] peak_imag;
  } peak_t;

  // Sample with its squared magnitude, passed from the squaring pipe to the window
  typedef struct packed {
    logic [MAG_W-1:0] mag;
    sample_t          sample;
  } mag_item_t;

endpackage

@@ design/wlmp_mag.sv @@
// ----------------------------------------------------------------------------
// wlmp_mag
// Squared-magnitude pipeline: input register, two squaring multipliers,
// then the final add. Each stage has its own valid bit and advances
// whenever the stage after it has room.
// ----------------------------------------------------------------------------
module wlmp_mag (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  wlmp_pkg::sample_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output wlmp_pkg::mag_item_t out_item
);
  import wlmp_pkg::*;

  logic                    v1, v2, v3;
  logic                    ready1, ready2, ready3;
  sample_t                 s1, s2, s3;
  logic signed [MAG_W-1:0] prod_re, prod_im;
  logic        [MAG_W-1:0] sq_re, sq_im;
  logic        [MAG_W-1:0] mag3;

  // Stage ready chain: a stage takes a beat when empty or draining
  assign ready3   = !v3 || out_ready;
  assign ready2   = !v2 || ready3;
  assign ready1   = !v1 || ready2;
  assign in_ready = ready1;

  // Square both parts; operands are 32-bit signed
  always_comb begin
    prod_re = s1.sample_real * s1.sample_real;
    prod_im = s1.sample_imag * s1.sample_imag;
  end

  // Advance stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (ready1) v1 <= in_valid;
      if (ready2) v2 <= v1;
      if (ready3) v3 <= v2;
    end
  end

  // Advance stage payloads
  always_ff @(posedge clk) begin
    if (ready1 && in_valid) begin
      s1 <= in_data;
    end
    if (ready2 && v1) begin
      s2    <= s1;
      sq_re <= prod_re;
      sq_im <= prod_im;
    end
    if (ready3 && v2) begin
      s3   <= s2;
      mag3 <= sq_re + sq_im;
    end
  end

  assign out_valid = v3;

  always_comb begin
    out_item.mag    = mag3;
    out_item.sample = s3;
  end

endmodule

@@ design/wlmp_win.sv @@
// ----------------------------------------------------------------------------
// wlmp_win
// Sliding window of squared magnitudes with delayed sample payloads. The
// newest beat is shifted in, then the centre is tested against the
// threshold and the monotonic slopes on both sides, all compares in
// parallel. A found peak is loaded into the output register.
// ----------------------------------------------------------------------------
module wlmp_win #(
  parameter int MAX_RADIUS = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         item_valid,
  output logic                         item_ready,
  input  wlmp_pkg::mag_item_t          item,
  input  logic [wlmp_pkg::MAG_W-1:0]    threshold_sq,
  input  logic [wlmp_pkg::RADIUS_W-1:0] radius,
  output logic                         out_valid,
  input  logic                         out_ready,
  output wlmp_pkg::peak_t              out_data
);
  import wlmp_pkg::*;

  localparam int WIN_LEN = 2 * MAX_RADIUS + 1;
  localparam int DLY_LEN = MAX_RADIUS + 1;
  localparam int RW      = $clog2(MAX_RADIUS + 1);
  localparam int SW      = $clog2(WIN_LEN + 1);

  logic [MAG_W-1:0] win [WIN_LEN];
  peak_t            dly [DLY_LEN];
  logic [SW-1:0]    seen;
  logic [SW-1:0]    seen_base;
  logic [SW-1:0]    seen_next;
  logic             scan_end;
  logic             held;

  logic [RW-1:0]    r;
  logic [MAG_W-1:0] centre_mag;
  peak_t            centre;
  logic             seen_ok;
  logic             slope_ok;
  logic             peak;
  logic             drain;
  logic             accept;

  // Clamp radius to MAX_RADIUS
  always_comb begin
    if (int'(radius) > MAX_RADIUS) r = RW'(MAX_RADIUS);
    else                           r = RW'(radius);
  end

  // Select the centre sample
  always_comb begin
    centre_mag = win[0];
    centre     = dly[0];
    for (int j = 1; j <= MAX_RADIUS; j++) begin
      if (int'(r) == j) begin
        centre_mag = win[j];
        centre     = dly[j];
      end
    end
  end

  // Check rising side into the centre and falling side after it
  always_comb begin
    slope_ok = 1'b1;
    for (int j = 1; j < WIN_LEN; j++) begin
      if (j <= int'(r)) begin
        if (win[j] < win[j-1]) slope_ok = 1'b0;
      end else if (j <= 2 * int'(r)) begin
        if (win[j] > win[j-1]) slope_ok = 1'b0;
      end
    end
  end

  assign seen_ok = int'(seen) >= 2 * int'(r) + 1;
  assign peak    = held && seen_ok && (centre_mag > threshold_sq) && slope_ok;

  // Drop a non-peak at once; a peak waits for room in the output register
  assign drain      = held && (!peak || !out_valid || out_ready);
  assign item_ready = !held || drain;
  assign accept     = item_valid && item_ready;

  // Restart the count after the last beat of a scan, saturate at window size
  always_comb begin
    seen_base = scan_end ? '0 : seen;
    if (int'(seen_base) < WIN_LEN) seen_next = seen_base + 1'b1;
    else                           seen_next = seen_base;
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (rst) begin
      held      <= 1'b0;
      seen      <= '0;
      scan_end  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        held     <= 1'b1;
        seen     <= seen_next;
        scan_end <= item.sample.scan_last;
      end else if (drain) begin
        held <= 1'b0;
      end
      if (drain && peak) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // Shift the window and delay line on each accepted beat
  always_ff @(posedge clk) begin
    if (accept) begin
      win[0]                <= item.mag;
      dly[0].peak_frequency <= item.sample.sample_frequency;
      dly[0].peak_real      <= item.sample.sample_real;
      dly[0].peak_imag      <= item.sample.sample_imag;
      for (int i = 1; i < WIN_LEN; i++) win[i] <= win[i-1];
      for (int i = 1; i < DLY_LEN; i++) dly[i] <= dly[i-1];
    end
    if (drain && peak) begin
      out_data <= centre;
    end
  end

endmodule

@@ design/windowed_local_max_peak_detect_unit.sv @@
// ----------------------------------------------------------------------------
// windowed_local_max_peak_detect_unit
// Threshold local-maximum peak detector over a stream of complex spectrum
// samples, using squared magnitudes and a window of 2*radius+1 samples.
//
//   channel   dir  handshake            payload
//   in        in   in_valid/in_ready    sample_t  (frequency, real, imag, last)
//   out       out  out_valid/out_ready  peak_t    (frequency, real, imag)
//   cfg       in   cfg_valid/cfg_ready  cfg_index, cfg_data (64 bit)
//
// One input beat per cycle sustained while out is not stalled; the squaring pipe,
// window stage and output register each move one beat a cycle.
// A peak is shown on out once the beat that completes its window has passed
// the input register, squares, add, window shift and output register.
// Reset clears all valid bits, the scan count and the registers
// (threshold_sq 0, radius 1); cfg_ready is always high.
// A stalled out channel backs up stage by stage; in_ready falls only once
// every stage holds a beat.
// ----------------------------------------------------------------------------
module windowed_local_max_peak_detect_unit #(
  parameter int MAX_RADIUS = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  wlmp_pkg::sample_t               in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output wlmp_pkg::peak_t                 out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [wlmp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [wlmp_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import wlmp_pkg::*;

  logic [MAG_W-1:0]    threshold_sq;
  logic [RADIUS_W-1:0] radius;
  logic                mag_valid;
  logic                mag_ready;
  mag_item_t           mag_item;

  assign cfg_ready = 1'b1;

  // Decode configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold_sq <= THRESHOLD_RESET;
      radius       <= RADIUS_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_THRESHOLD_SQ: threshold_sq <= cfg_data[MAG_W-1:0];
        CFG_RADIUS:       radius       <= cfg_data[RADIUS_W-1:0];
        default: ;
      endcase
    end
  end

  wlmp_mag u_mag (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (mag_valid),
    .out_ready (mag_ready),
    .out_item  (mag_item)
  );

  wlmp_win #(
    .MAX_RADIUS (MAX_RADIUS)
  ) u_win (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (mag_valid),
    .item_ready   (mag_ready),
    .item         (mag_item),
    .threshold_sq (threshold_sq),
    .radius       (radius),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data)
  );

endmodule

@@ design/wlmp_check.sv @@
// ----------------------------------------------------------------------------
// wlmp_check
// Port-level checks for the peak detector, bound to the top level.
// ----------------------------------------------------------------------------
module wlmp_check (
  input logic              clk,
  input logic              rst,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input wlmp_pkg::peak_t   out_data
);
  import wlmp_pkg::*;

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // Reset empties the output register
  a_rst_out: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  // Reset leaves every stage empty, so input is open
  a_rst_in: assert property (@(posedge clk)
    rst |=> in_ready)
    else $error("input blocked after reset");

  // Input is blocked only by a waiting result
  a_no_false_stall: assert property (@(posedge clk) disable iff (rst)
    !out_valid || out_ready |-> in_ready)
    else $error("input blocked with free output");

endmodule

bind windowed_local_max_peak_detect_unit wlmp_check u_wlmp_check (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
